// File: rtl/htok_pkg.sv
package htok_pkg;

    // parse phases
    localparam logic [3:0] PH_METHOD  = 4'd0;
    localparam logic [3:0] PH_URL     = 4'd1;
    localparam logic [3:0] PH_VERSION = 4'd2;
    localparam logic [3:0] PH_SKIP    = 4'd3;
    localparam logic [3:0] PH_LINE    = 4'd4;
    localparam logic [3:0] PH_LINE_CR = 4'd5;
    localparam logic [3:0] PH_NAME    = 4'd6;
    localparam logic [3:0] PH_SPACES  = 4'd7;
    localparam logic [3:0] PH_VALUE   = 4'd8;

    // result kinds
    localparam logic [3:0] KIND_METHOD_DONE  = 4'd0;
    localparam logic [3:0] KIND_URL_BYTE     = 4'd1;
    localparam logic [3:0] KIND_URL_DONE     = 4'd2;
    localparam logic [3:0] KIND_VERSION_BYTE = 4'd3;
    localparam logic [3:0] KIND_VERSION_DONE = 4'd4;
    localparam logic [3:0] KIND_NAME_BYTE    = 4'd5;
    localparam logic [3:0] KIND_NAME_DONE    = 4'd6;
    localparam logic [3:0] KIND_VALUE_BYTE   = 4'd7;
    localparam logic [3:0] KIND_HEADER_DONE  = 4'd8;
    localparam logic [3:0] KIND_REQ_DONE     = 4'd9;

    // method codes
    localparam logic [2:0] METHOD_CONNECT = 3'd0;
    localparam logic [2:0] METHOD_GET     = 3'd1;
    localparam logic [2:0] METHOD_HEAD    = 3'd2;
    localparam logic [2:0] METHOD_POST    = 3'd3;
    localparam logic [2:0] METHOD_PUT     = 3'd4;

    // characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;

    // method candidates in priority order
    localparam int         NUM_CAND  = 4;
    localparam logic [2:0] MPOS_MAX  = 3'd7;
    localparam logic [0:NUM_CAND-1][0:6][7:0] CAND_TEXT =
        {"CONNECT", "GET", 32'h0, "HEAD", 24'h0, "POST", 24'h0};
    localparam logic [0:NUM_CAND-1][2:0] CAND_LEN = {3'd7, 3'd3, 3'd4, 3'd4};

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] payload_byte;
        logic [2:0] method_code;
        logic       last_of_run;
    } t_result;

    // results caused by one byte
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_res_pair;

    function automatic t_result mk_result(logic [3:0] kind, logic [7:0] b,
                                          logic [2:0] code);
        t_result r;
        r.kind         = kind;
        r.payload_byte = b;
        r.method_code  = code;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

endpackage

// File: rtl/htok_if.sv
// raw byte channel
interface htok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// tagged result channel
interface htok_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] kind;
    logic [7:0] payload_byte;
    logic [2:0] method_code;
    logic       last_of_run;

    modport source (output valid, output kind, output payload_byte,
                    output method_code, output last_of_run, input ready);
    modport sink   (input valid, input kind, input payload_byte,
                    input method_code, input last_of_run, output ready);
endinterface

// File: rtl/http_request_head_tokenizer_unit.sv
// a byte is held in the input register, then its results go through the result queue
// throughput: one byte per cycle while the result queue has room for two results
// a byte with no result (method byte, skipped byte, leading space, line-start cr) uses no slot
// reset: i_rst_n synchronous active low; returns to the method token with all candidates
// alive and empties the input register and the result queue
module http_request_head_tokenizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    htok_in_if.sink     i_in,
    htok_out_if.source  o_out
);
    import htok_pkg::*;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             proc_fire;
    t_res_pair        res;
    t_result          head;
    logic [FIFO_AW:0] q_count;
    logic [1:0]       push_cnt;

    // process the held byte when the queue has room for two results
    assign proc_fire  = r_in_valid && (q_count <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign i_in.ready = !r_in_valid || proc_fire;
    assign push_cnt   = proc_fire ? res.cnt : 2'd0;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
        end
    end

    htok_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (proc_fire),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    htok_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_push0    (res.res0),
        .i_push1    (res.res1),
        .i_pop      (o_out.ready),
        .o_head     (head),
        .o_count    (q_count)
    );

    // output transfer from the queue head
    assign o_out.valid        = (q_count != '0);
    assign o_out.kind         = head.kind;
    assign o_out.payload_byte = head.payload_byte;
    assign o_out.method_code  = head.method_code;
    assign o_out.last_of_run  = head.last_of_run;

    // held byte stays until processed
    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !proc_fire) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held byte lost before processing");

    // ready whenever the input register is empty
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_in.ready)
        else $error("input stalled with empty register");

    // results pushed by a processed byte are offered on the output
    a_out_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && res.cnt != 2'd0) |=> o_out.valid)
        else $error("pushed result not offered");

endmodule

// File: rtl/htok_core.sv
module htok_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_byte,
    output htok_pkg::t_res_pair o_res
);
    import htok_pkg::*;

    logic [3:0] r_phase, n_phase;
    logic [2:0] r_mpos, n_mpos;
    logic [3:0] r_alive, n_alive;
    t_res_pair  res;
    logic [3:0] alive_upd;
    logic [2:0] code;

    // method candidate filter
    always_comb begin
        alive_upd = r_alive;
        if (r_mpos != MPOS_MAX) begin
            for (int k = 0; k < NUM_CAND; k++) begin
                if (r_mpos < CAND_LEN[k] && i_byte != CAND_TEXT[k][r_mpos]) begin
                    alive_upd[k] = 1'b0;
                end
            end
        end
        code = METHOD_PUT;
        if (alive_upd[0])      code = METHOD_CONNECT;
        else if (alive_upd[1]) code = METHOD_GET;
        else if (alive_upd[2]) code = METHOD_HEAD;
        else if (alive_upd[3]) code = METHOD_POST;
    end

    // phase transitions and result generation
    always_comb begin
        n_phase = r_phase;
        n_mpos  = r_mpos;
        n_alive = r_alive;
        res     = '0;
        unique case (r_phase) inside
            PH_URL: begin
                res.cnt = 2'd1;
                if (i_byte == CH_SPACE) begin
                    n_phase  = PH_VERSION;
                    res.res0 = mk_result(KIND_URL_DONE, 8'h0, 3'd0);
                end else begin
                    res.res0 = mk_result(KIND_URL_BYTE, i_byte, 3'd0);
                end
            end
            PH_VERSION: begin
                res.cnt = 2'd1;
                if (i_byte == CH_CR || i_byte == CH_LF) begin
                    n_phase  = PH_SKIP;
                    res.res0 = mk_result(KIND_VERSION_DONE, 8'h0, 3'd0);
                end else begin
                    res.res0 = mk_result(KIND_VERSION_BYTE, i_byte, 3'd0);
                end
            end
            PH_SKIP: begin
                n_phase = PH_LINE;
            end
            PH_LINE, PH_NAME: begin
                if (r_phase == PH_LINE && i_byte == CH_CR) begin
                    n_phase = PH_LINE_CR;
                end else begin
                    res.cnt = 2'd1;
                    if (i_byte == CH_COLON) begin
                        n_phase  = PH_SPACES;
                        res.res0 = mk_result(KIND_NAME_DONE, 8'h0, 3'd0);
                    end else begin
                        n_phase  = PH_NAME;
                        res.res0 = mk_result(KIND_NAME_BYTE, i_byte, 3'd0);
                    end
                end
            end
            PH_LINE_CR: begin
                if (i_byte == CH_LF) begin
                    n_phase  = PH_METHOD;
                    n_mpos   = 3'd0;
                    n_alive  = 4'hf;
                    res.cnt  = 2'd1;
                    res.res0 = mk_result(KIND_REQ_DONE, 8'h0, 3'd0);
                end else begin
                    // lone cr turns into a name byte ahead of this one
                    res.cnt  = 2'd2;
                    res.res0 = mk_result(KIND_NAME_BYTE, CH_CR, 3'd0);
                    if (i_byte == CH_COLON) begin
                        n_phase  = PH_SPACES;
                        res.res1 = mk_result(KIND_NAME_DONE, 8'h0, 3'd0);
                    end else begin
                        n_phase  = PH_NAME;
                        res.res1 = mk_result(KIND_NAME_BYTE, i_byte, 3'd0);
                    end
                end
            end
            PH_SPACES, PH_VALUE: begin
                if (r_phase == PH_VALUE || i_byte != CH_SPACE) begin
                    res.cnt = 2'd1;
                    if (i_byte == CH_CR || i_byte == CH_LF) begin
                        n_phase  = PH_SKIP;
                        res.res0 = mk_result(KIND_HEADER_DONE, 8'h0, 3'd0);
                    end else begin
                        n_phase  = PH_VALUE;
                        res.res0 = mk_result(KIND_VALUE_BYTE, i_byte, 3'd0);
                    end
                end
            end
            default: begin
                // method token, also any unused phase code
                n_alive = alive_upd;
                if (r_mpos != MPOS_MAX) begin
                    n_mpos = r_mpos + 3'd1;
                end
                if (i_byte == CH_SPACE) begin
                    n_phase  = PH_URL;
                    res.cnt  = 2'd1;
                    res.res0 = mk_result(KIND_METHOD_DONE, 8'h0, code);
                end else begin
                    n_phase = PH_METHOD;
                end
            end
        endcase
        // mark the final result of the run
        if (res.cnt == 2'd1) res.res0.last_of_run = 1'b1;
        if (res.cnt == 2'd2) res.res1.last_of_run = 1'b1;
    end

    assign o_res = res;

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_METHOD;
            r_mpos  <= 3'd0;
            r_alive <= 4'hf;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_mpos  <= n_mpos;
            r_alive <= n_alive;
        end
    end

    // two results only come from a cr at line start
    a_two_from_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && res.cnt == 2'd2) |-> r_phase == PH_LINE_CR)
        else $error("two results outside lone cr");

    // request done restarts the method match
    a_req_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && res.cnt == 2'd1 && res.res0.kind == KIND_REQ_DONE)
        |=> (r_phase == PH_METHOD && r_mpos == 3'd0 && r_alive == 4'hf))
        else $error("request done did not restart method match");

    // candidates only die while in the method token
    a_alive_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_phase != PH_METHOD && r_phase != PH_LINE_CR)
        |=> $stable(r_alive))
        else $error("candidate set changed outside method token");

endmodule

// File: rtl/htok_fifo.sv
module htok_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_push_cnt,
    input  htok_pkg::t_result    i_push0,
    input  htok_pkg::t_result    i_push1,
    input  logic                 i_pop,
    output htok_pkg::t_result    o_head,
    output logic [htok_pkg::FIFO_AW:0] o_count
);
    import htok_pkg::*;

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FIFO_AW:0]     r_count, n_count;
    logic                 pop_ok;

    assign pop_ok  = i_pop && (r_count != '0);
    assign n_count = r_count + {{(FIFO_AW-1){1'b0}}, i_push_cnt}
                     - {{FIFO_AW{1'b0}}, pop_ok};

    // storage writes, up to two entries per cycle
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr_ptr + FIFO_AW'(1)] <= i_push1;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(i_push_cnt);
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= n_count;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    // no overflow
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count + {{(FIFO_AW-1){1'b0}}, i_push_cnt}) <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    // pointer distance matches fill count
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[FIFO_AW-1:0])
        else $error("queue pointers disagree with count");

    // a pop with no push lowers the count by one
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_ok && i_push_cnt == 2'd0) |=> r_count == $past(r_count) - 1'b1)
        else $error("pop did not lower count");

endmodule

// File: tb/http_request_head_tokenizer_unit_test.sv
module http_request_head_tokenizer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import htok_pkg::*;

    localparam int         RANDOM_ITEMS   = 1650;
    localparam int         LONG_HOLD      = 200;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         TAIL_CYCLES    = 20;
    localparam int         HOLD_AFTER     = 400;
    localparam logic [2:0] NO_METHOD      = 3'd0;

    // one row of stimulus; a typed row carries its own expected result
    typedef struct {
        logic [7:0] data_byte;
        bit         typed;
        t_result    token;
    } t_stim;

    logic i_clk;
    logic i_rst_n;

    htok_in_if  in_ch();
    htok_out_if out_ch();

    t_stim      byte_stream[$];
    t_result    token_fifo[$];
    int         accepted_cnt = 0;
    int         calm_from    = 0;
    int         err_cnt      = 0;
    int         stall_cycles = 0;

    // tokenizer shadow state
    logic [3:0] parse_phase;
    logic [2:0] method_pos;
    logic [3:0] cand_alive;
    string      cand_word[NUM_CAND] = '{"CONNECT", "GET", "HEAD", "POST"};
    logic [2:0] cand_code[NUM_CAND] = '{METHOD_CONNECT, METHOD_GET, METHOD_HEAD, METHOD_POST};

    http_request_head_tokenizer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_result make_token(logic [3:0] kind, logic [7:0] b, logic [2:0] code);
        t_result t;
        t.kind         = kind;
        t.payload_byte = b;
        t.method_code  = code;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    task automatic push_token(logic [3:0] kind, logic [7:0] b = 8'h00,
                              logic [2:0] code = NO_METHOD);
        token_fifo.push_back(make_token(kind, b, code));
    endtask

    task automatic restart_parser();
        parse_phase = PH_METHOD;
        method_pos  = 3'd0;
        cand_alive  = '1;
    endtask

    // only a colon ends a name
    task automatic take_name_byte(logic [7:0] b);
        if (b == CH_COLON) begin
            parse_phase = PH_SPACES;
            push_token(KIND_NAME_DONE);
        end else begin
            parse_phase = PH_NAME;
            push_token(KIND_NAME_BYTE, b);
        end
    endtask

    task automatic take_value_byte(logic [7:0] b);
        if (b == CH_CR || b == CH_LF) begin
            parse_phase = PH_SKIP;
            push_token(KIND_HEADER_DONE);
        end else begin
            parse_phase = PH_VALUE;
            push_token(KIND_VALUE_BYTE, b);
        end
    endtask

    // advance the shadow tokenizer by one byte and queue what it yields
    task automatic tokenize_byte(logic [7:0] b);
        int         first;
        logic [2:0] code;
        first = token_fifo.size();
        case (parse_phase)
            PH_URL: begin
                if (b == CH_SPACE) begin
                    parse_phase = PH_VERSION;
                    push_token(KIND_URL_DONE);
                end else begin
                    push_token(KIND_URL_BYTE, b);
                end
            end
            PH_VERSION: begin
                if (b == CH_CR || b == CH_LF) begin
                    parse_phase = PH_SKIP;
                    push_token(KIND_VERSION_DONE);
                end else begin
                    push_token(KIND_VERSION_BYTE, b);
                end
            end
            PH_SKIP: parse_phase = PH_LINE;
            PH_LINE: begin
                if (b == CH_CR) parse_phase = PH_LINE_CR;
                else take_name_byte(b);
            end
            PH_LINE_CR: begin
                if (b == CH_LF) begin
                    restart_parser();
                    push_token(KIND_REQ_DONE);
                end else begin
                    // lone cr turns into a name byte
                    push_token(KIND_NAME_BYTE, CH_CR);
                    take_name_byte(b);
                end
            end
            PH_NAME:   take_name_byte(b);
            PH_SPACES: if (b != CH_SPACE) take_value_byte(b);
            PH_VALUE:  take_value_byte(b);
            default: begin
                // prefix match stops after the longest candidate
                if (method_pos < MPOS_MAX) begin
                    for (int k = 0; k < NUM_CAND; k++) begin
                        if (int'(method_pos) < cand_word[k].len() &&
                            b != cand_word[k][method_pos])
                            cand_alive[k] = 1'b0;
                    end
                    method_pos++;
                end
                if (b == CH_SPACE) begin
                    code = METHOD_PUT;
                    for (int k = NUM_CAND - 1; k >= 0; k--)
                        if (cand_alive[k]) code = cand_code[k];
                    parse_phase = PH_URL;
                    push_token(KIND_METHOD_DONE, 8'h00, code);
                end
            end
        endcase
        if (token_fifo.size() > first)
            token_fifo[token_fifo.size() - 1].last_of_run = 1'b1;
    endtask

    task automatic add_stim(logic [7:0] d, bit typed = 1'b0,
                            logic [3:0] kind = KIND_METHOD_DONE,
                            logic [7:0] pay = 8'h00, logic [2:0] code = NO_METHOD);
        t_stim row;
        row.data_byte         = d;
        row.typed             = typed;
        row.token             = make_token(kind, pay, code);
        row.token.last_of_run = 1'b1;
        byte_stream.push_back(row);
    endtask

    // mostly printable, sometimes any byte, never the two excluded ones
    function automatic logic [7:0] pick_byte(logic [7:0] not_a, logic [7:0] not_b);
        logic [7:0] b;
        do begin
            if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(0, 255));
            else b = 8'($urandom_range(8'h21, 8'h7e));
        end while (b == not_a || b == not_b);
        return b;
    endfunction

    task automatic add_line_end(logic [7:0] term);
        add_stim(term);
        if (term == CH_CR && $urandom_range(0, 3) != 0) add_stim(CH_LF);
        else add_stim(8'($urandom_range(0, 255)));
    endtask

    // one request head with random content, or a burst of noise
    task automatic add_request();
        string      word;
        int         tail;
        int         len;
        logic [7:0] b;
        logic [7:0] prev;
        if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 12)) add_stim(8'($urandom_range(0, 255)));
            return;
        end
        // method token
        word = "";
        tail = 0;
        case ($urandom_range(0, 7)) inside
            0, 1, 2, 3: word = cand_word[$urandom_range(0, NUM_CAND - 1)];
            4: word = "PUT";
            5: begin
                word = cand_word[$urandom_range(0, NUM_CAND - 1)];
                word = word.substr(0, $urandom_range(0, word.len()) - 1);
                tail = $urandom_range(0, 3);
            end
            default: tail = $urandom_range(0, 10);
        endcase
        for (int i = 0; i < word.len(); i++) add_stim(word[i]);
        repeat (tail) begin
            if ($urandom_range(0, 5) == 0) add_stim($urandom_range(0, 1) ? CH_CR : CH_LF);
            else add_stim(pick_byte(CH_SPACE, CH_SPACE));
        end
        add_stim(CH_SPACE);
        // url and version
        repeat ($urandom_range(0, 6)) add_stim(pick_byte(CH_SPACE, CH_SPACE));
        add_stim(CH_SPACE);
        repeat ($urandom_range(0, 5)) add_stim(pick_byte(CH_CR, CH_LF));
        add_line_end($urandom_range(0, 3) != 0 ? CH_CR : CH_LF);
        // header lines
        repeat ($urandom_range(0, 3)) begin
            len  = $urandom_range(0, 5);
            prev = 8'h00;
            for (int i = 0; i < len; i++) begin
                b = pick_byte(CH_COLON, CH_COLON);
                if (i == 0 && $urandom_range(0, 4) == 0) b = CH_CR;
                if (i == 1 && prev == CH_CR && b == CH_LF) b = "a";
                add_stim(b);
                prev = b;
            end
            add_stim(CH_COLON);
            repeat ($urandom_range(0, 2)) add_stim(CH_SPACE);
            repeat ($urandom_range(0, 5)) add_stim(pick_byte(CH_CR, CH_LF));
            add_line_end($urandom_range(0, 3) != 0 ? CH_CR : CH_LF);
        end
        add_stim(CH_CR);
        add_stim(CH_LF);
    endtask

    function automatic void check_field(string fld, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", fld, want, got);
            err_cnt++;
        end
    endfunction

    // input transfers feed the shadow tokenizer
    always @(posedge i_clk) begin : watch_in
        int    before_cnt;
        t_stim row;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            row        = byte_stream[accepted_cnt];
            before_cnt = token_fifo.size();
            tokenize_byte(row.data_byte);
            if (row.typed) begin
                while (token_fifo.size() > before_cnt) void'(token_fifo.pop_back());
                token_fifo.push_back(row.token);
            end
            accepted_cnt++;
        end
    end

    // output transfers are checked against the oldest expected token
    always @(posedge i_clk) begin : watch_out
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (token_fifo.size() == 0) begin
                $error("unexpected result: kind 0x%0h payload 0x%0h",
                       out_ch.kind, out_ch.payload_byte);
                err_cnt++;
            end else begin
                want = token_fifo.pop_front();
                check_field("kind", want.kind, out_ch.kind);
                check_field("payload_byte", want.payload_byte, out_ch.payload_byte);
                check_field("method_code", want.method_code, out_ch.method_code);
                check_field("last_of_run", want.last_of_run, out_ch.last_of_run);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("http_request_head_tokenizer_unit_test: FAIL");
            $finish;
        end
    end

    // result sink with random back pressure and one long hold-off
    initial begin : drain_results
        int hold_odds;
        bit held;
        out_ch.ready <= 1'b0;
        hold_odds = 0;
        held      = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!held && accepted_cnt >= HOLD_AFTER) begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (accepted_cnt < calm_from && hold_odds != 0 &&
                         $urandom_range(0, 9) < hold_odds) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            if ($urandom_range(0, 63) == 0) hold_odds = $urandom_range(0, 3);
        end
    end

    // stimulus, reset and end of run
    initial begin : drive_bytes
        int gap_odds;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'h00;
        gap_odds = 0;
        restart_parser();

        // directed head: extremes, every phase but value, lone cr, empty name and value
        add_stim("G");
        add_stim("E");
        add_stim("T");
        add_stim(CH_SPACE, 1'b1, KIND_METHOD_DONE, 8'h00, METHOD_GET);
        add_stim(8'hff, 1'b1, KIND_URL_BYTE, 8'hff);
        add_stim(CH_SPACE, 1'b1, KIND_URL_DONE);
        add_stim(8'h00, 1'b1, KIND_VERSION_BYTE, 8'h00);
        add_stim(CH_LF, 1'b1, KIND_VERSION_DONE);
        add_stim(CH_CR);
        add_stim(CH_CR);
        add_stim(8'h00);
        add_stim(CH_COLON, 1'b1, KIND_NAME_DONE);
        add_stim(CH_SPACE);
        add_stim(CH_CR, 1'b1, KIND_HEADER_DONE);
        add_stim(CH_LF);
        add_stim(CH_COLON, 1'b1, KIND_NAME_DONE);
        add_stim(CH_LF, 1'b1, KIND_HEADER_DONE);
        add_stim("x");
        add_stim(CH_CR);
        add_stim(CH_LF, 1'b1, KIND_REQ_DONE);
        add_stim("P");
        add_stim(CH_SPACE, 1'b1, KIND_METHOD_DONE, 8'h00, METHOD_PUT);
        add_stim(CH_SPACE, 1'b1, KIND_URL_DONE);
        add_stim(CH_CR, 1'b1, KIND_VERSION_DONE);
        add_stim(CH_LF);
        add_stim(CH_CR);
        add_stim(CH_LF, 1'b1, KIND_REQ_DONE);

        // random request heads
        calm_from = byte_stream.size() + RANDOM_ITEMS;
        while (byte_stream.size() < calm_from) add_request();
        calm_from = byte_stream.size() * 9 / 10;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < byte_stream.size(); i++) begin
            if (i % 64 == 0) gap_odds = $urandom_range(0, 3);
            if (i < calm_from && gap_odds != 0 && $urandom_range(0, 9) < gap_odds) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            in_ch.valid     <= 1'b1;
            in_ch.data_byte <= byte_stream[i].data_byte;
            @(posedge i_clk);
            while (!in_ch.ready) @(posedge i_clk);
        end
        in_ch.valid <= 1'b0;

        // drain, then let any straggler show up
        @(posedge i_clk);
        while (token_fifo.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("http_request_head_tokenizer_unit_test: PASS");
        end else begin
            $display("http_request_head_tokenizer_unit_test: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/htok_pkg.sv
rtl/htok_if.sv
rtl/htok_core.sv
rtl/htok_fifo.sv
rtl/http_request_head_tokenizer_unit.sv
tb/http_request_head_tokenizer_unit_test.sv
